@@ sv/kdb_pkg.sv @@
// Shared types, codes and segment tables for the keypad, display and buzzer controller.
`default_nettype none
package kdb_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY    = 2'd1,
    OP_BYTE   = 2'd2,
    OP_ANALOG = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_HOLDOFF    = 3'd1,
    CFG_SAMPLE_INT = 3'd2,
    CFG_BEEP       = 3'd3,
    CFG_KEY_TONE   = 3'd4,
    CFG_RX_TONE    = 3'd5,
    CFG_DUTY_STEP  = 3'd6
  } cfg_idx_t;

  // Digit positions: high, middle, low
  localparam logic [1:0] DIG_HIGH = 2'd0;
  localparam logic [1:0] DIG_MID  = 2'd1;
  localparam logic [1:0] DIG_LOW  = 2'd2;

  localparam logic [4:0] KEY_ENT  = 5'd14;
  localparam logic [4:0] KEY_ESC  = 5'd15;
  localparam logic [4:0] KEY_UP   = 5'd16;
  localparam logic [4:0] KEY_DOWN = 5'd17;

  localparam logic [7:0] SEG_DOT = 8'h80;

  localparam logic [0:2][7:0] WORD_ENT  = {8'h79, 8'h54, 8'h78};
  localparam logic [0:2][7:0] WORD_ESC  = {8'h79, 8'h6D, 8'h39};
  localparam logic [0:2][7:0] WORD_UP   = {8'h50, 8'h23, 8'h44};
  localparam logic [0:2][7:0] WORD_DOWN = {8'h60, 8'h1C, 8'h42};

  typedef struct packed {
    logic       valid;
    logic [4:0] code;
  } key_t;

  function automatic logic [7:0] seg_hex(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      4'd10:   s = 8'h77;
      4'd11:   s = 8'h7C;
      4'd12:   s = 8'h39;
      4'd13:   s = 8'h5E;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Keypad layout: column by row
  function automatic logic [4:0] key_map(input logic [1:0] col, input logic [1:0] row);
    logic [4:0] k;
    case ({col, row})
      4'b00_00: k = 5'd1;
      4'b00_01: k = 5'd4;
      4'b00_10: k = 5'd7;
      4'b00_11: k = KEY_ENT;
      4'b01_00: k = 5'd2;
      4'b01_01: k = 5'd5;
      4'b01_10: k = 5'd8;
      4'b01_11: k = 5'd0;
      4'b10_00: k = 5'd3;
      4'b10_01: k = 5'd6;
      4'b10_10: k = 5'd9;
      4'b10_11: k = KEY_ESC;
      4'b11_00: k = 5'd10;
      4'b11_01: k = 5'd11;
      4'b11_10: k = 5'd12;
      4'b11_11: k = 5'd13;
      default:  k = 5'd0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ sv/kdb_key_decode.sv @@
// Keypad and push-button decoder: driven column plus row lines to a key code.
`default_nettype none
module kdb_key_decode (
  input  wire logic [3:0] column,
  input  wire logic [3:0] rows,
  input  wire logic       up,
  input  wire logic       down,
  output kdb_pkg::key_t   key
);

  logic [1:0] col;
  logic [1:0] row;

  always_comb begin
    case (column)
      4'b0001: col = 2'd0;
      4'b0010: col = 2'd1;
      4'b0100: col = 2'd2;
      default: col = 2'd3;
    endcase
  end

  // Highest row wins
  always_comb begin
    if (rows[3]) begin
      row = 2'd3;
    end else if (rows[2]) begin
      row = 2'd2;
    end else if (rows[1]) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end
  end

  always_comb begin
    key.valid = (rows != 4'd0) | up | down;
    if (up) begin
      key.code = kdb_pkg::KEY_UP;
    end else if (down) begin
      key.code = kdb_pkg::KEY_DOWN;
    end else if (rows != 4'd0) begin
      key.code = kdb_pkg::key_map(col, row);
    end else begin
      key.code = 5'd0;
    end
  end

endmodule
`default_nettype wire

@@ sv/keypad_display_buzzer_controller.sv @@
// Top level of the keypad, three-digit display and buzzer controller.
// Usage:
//   The in_ channel carries one item per beat: a timer tick, a keypad sample,
//   a received byte or an analog sample (in_op). Each item updates the
//   counters, scan position, display patterns or LED duty, as its kind asks,
//   in one pass and yields exactly one result beat on the out_ channel:
//   column drive, lit digit, its segments, buzzer level, duty, key/sample flags.
//   out_valid rises in the cycle after a beat is accepted. While the receiver
//   keeps up, throughput is one item per cycle; the state update is a single
//   combinational pass between the state registers and the output register.
//   When the receiver stalls, the output register holds its beat and
//   in_ready drops until the beat is taken; the state is not touched.
//   Reset (synchronous, rst_n low) loads the configuration defaults, clears
//   the counters, blanks the display, starts the scan at column 1 and the
//   low digit and empties the output register.
//   The cfg_ port writes one register per cycle with cfg_we; write it only
//   while no beat is in flight.
`default_nettype none
module keypad_display_buzzer_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [3:0]  in_row_lines,
  input  wire logic        in_up_button,
  input  wire logic        in_down_button,
  input  wire logic [7:0]  in_byte_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_column_drive,
  output logic [2:0]       out_digit_enable,
  output logic [7:0]       out_segment_lines,
  output logic             out_buzzer_level,
  output logic [7:0]       out_duty_value,
  output logic             out_key_valid,
  output logic [4:0]       out_key_code,
  output logic             out_sample_taken
);

  // Configuration registers
  logic [15:0] debounce_ticks_r, holdoff_ticks_r, sample_int_r, beep_ticks_r;
  logic [7:0]  key_tone_r, rx_tone_r, duty_step_r;

  // Block state
  logic [15:0] debounce_left_r, debounce_left_nxt;
  logic [15:0] holdoff_left_r, holdoff_left_nxt;
  logic [15:0] beep_left_r, beep_left_nxt;
  logic [7:0]  tone_count_r, tone_count_nxt;
  logic [7:0]  tone_period_r, tone_period_nxt;
  logic        tone_level_r, tone_level_nxt;
  logic [3:0]  column_r, column_nxt;
  logic [1:0]  lit_r, lit_nxt;
  logic [7:0]  dig_r   [3];
  logic [7:0]  dig_nxt [3];
  logic        word_r, word_nxt;
  logic [7:0]  duty_r, duty_nxt;

  // Output register
  logic        out_valid_r;
  logic [3:0]  out_column_r;
  logic [2:0]  out_digit_r;
  logic [7:0]  out_seg_r;
  logic        out_buzz_r;
  logic [7:0]  out_duty_r;
  logic        out_kv_r;
  logic [4:0]  out_kc_r;
  logic        out_st_r;

  logic        in_fire;
  kdb_pkg::op_t op;
  kdb_pkg::key_t key;
  logic        key_take;
  logic [4:0]  key_code_out;
  logic        sample_take;

  // Decimal split of the byte value
  logic [1:0]  dec_h;
  logic [6:0]  dec_r;
  logic [14:0] dec_prod;
  logic [3:0]  dec_t;
  logic [3:0]  dec_o;
  logic [7:0]  seg_h, seg_t, seg_o;

  logic [7:0]  tone_inc;
  logic [8:0]  duty_sum;
  logic [7:0]  shift_mid, shift_low;
  logic [1:0]  lit_idx;

  // Accept a new beat whenever the output slot is free or draining
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;
  assign op       = kdb_pkg::op_t'(in_op);

  kdb_key_decode u_key (
    .column (column_r),
    .rows   (in_row_lines),
    .up     (in_up_button),
    .down   (in_down_button),
    .key    (key)
  );

  // Hundreds by compare and subtract; tens by reciprocal multiply (x*205)>>11
  always_comb begin
    if (in_byte_value >= 8'd200) begin
      dec_h = 2'd2;
      dec_r = 7'(in_byte_value - 8'd200);
    end else if (in_byte_value >= 8'd100) begin
      dec_h = 2'd1;
      dec_r = 7'(in_byte_value - 8'd100);
    end else begin
      dec_h = 2'd0;
      dec_r = in_byte_value[6:0];
    end
    dec_prod = 15'(dec_r) * 15'd205;
    dec_t    = dec_prod[14:11];
    dec_o    = 4'(dec_r - 7'(dec_t) * 7'd10);
    seg_h    = kdb_pkg::seg_hex({2'b00, dec_h});
    seg_t    = kdb_pkg::seg_hex(dec_t);
    seg_o    = kdb_pkg::seg_hex(dec_o);
  end

  assign key_take    = (op == kdb_pkg::OP_KEY) && (debounce_left_r == 16'd0) && key.valid;
  assign sample_take = (op == kdb_pkg::OP_ANALOG) && (holdoff_left_r == 16'd0);
  assign key_code_out = key_take ? key.code : 5'd0;
  assign tone_inc    = tone_count_r + 8'd1;
  assign duty_sum    = {1'b0, duty_r} + {1'b0, duty_step_r};
  // A digit after a word starts from a blank middle and low
  assign shift_mid   = word_r ? 8'h00 : dig_r[kdb_pkg::DIG_MID];
  assign shift_low   = word_r ? 8'h00 : dig_r[kdb_pkg::DIG_LOW];

  // Next state for one item
  always_comb begin
    debounce_left_nxt = debounce_left_r;
    holdoff_left_nxt  = holdoff_left_r;
    beep_left_nxt     = beep_left_r;
    tone_count_nxt    = tone_count_r;
    tone_period_nxt   = tone_period_r;
    tone_level_nxt    = tone_level_r;
    column_nxt        = column_r;
    lit_nxt           = lit_r;
    dig_nxt[0]        = dig_r[0];
    dig_nxt[1]        = dig_r[1];
    dig_nxt[2]        = dig_r[2];
    word_nxt          = word_r;
    duty_nxt          = duty_r;
    case (op)
      kdb_pkg::OP_TICK: begin
        if (debounce_left_r != 16'd0) begin
          debounce_left_nxt = debounce_left_r - 16'd1;
        end
        if (holdoff_left_r != 16'd0) begin
          holdoff_left_nxt = holdoff_left_r - 16'd1;
        end
        if (beep_left_r != 16'd0) begin
          beep_left_nxt = beep_left_r - 16'd1;
          if (tone_inc >= tone_period_r) begin
            tone_count_nxt = 8'd0;
            tone_level_nxt = ~tone_level_r;
          end else begin
            tone_count_nxt = tone_inc;
          end
        end else begin
          tone_level_nxt = 1'b0;
        end
        // Rotate column; restart at column 1 on a bad code
        case (column_r)
          4'b0001: column_nxt = 4'b0010;
          4'b0010: column_nxt = 4'b0100;
          4'b0100: column_nxt = 4'b1000;
          default: column_nxt = 4'b0001;
        endcase
        // Scan order high -> low -> middle -> high
        case (lit_r)
          kdb_pkg::DIG_HIGH: lit_nxt = kdb_pkg::DIG_LOW;
          kdb_pkg::DIG_MID:  lit_nxt = kdb_pkg::DIG_HIGH;
          default:           lit_nxt = kdb_pkg::DIG_MID;
        endcase
      end
      kdb_pkg::OP_KEY: begin
        if (key_take) begin
          debounce_left_nxt = debounce_ticks_r;
          holdoff_left_nxt  = holdoff_ticks_r;
          tone_period_nxt   = key_tone_r;
          beep_left_nxt     = beep_ticks_r;
          if (key.code < kdb_pkg::KEY_ENT) begin
            word_nxt   = 1'b0;
            dig_nxt[0] = shift_mid;
            dig_nxt[1] = shift_low;
            dig_nxt[2] = kdb_pkg::seg_hex(key.code[3:0]);
          end else begin
            word_nxt = 1'b1;
            case (key.code)
              kdb_pkg::KEY_ENT: begin
                dig_nxt[0] = kdb_pkg::WORD_ENT[0];
                dig_nxt[1] = kdb_pkg::WORD_ENT[1];
                dig_nxt[2] = kdb_pkg::WORD_ENT[2];
              end
              kdb_pkg::KEY_ESC: begin
                dig_nxt[0] = kdb_pkg::WORD_ESC[0];
                dig_nxt[1] = kdb_pkg::WORD_ESC[1];
                dig_nxt[2] = kdb_pkg::WORD_ESC[2];
              end
              kdb_pkg::KEY_UP: begin
                dig_nxt[0] = kdb_pkg::WORD_UP[0];
                dig_nxt[1] = kdb_pkg::WORD_UP[1];
                dig_nxt[2] = kdb_pkg::WORD_UP[2];
                duty_nxt   = duty_sum[8] ? 8'hFF : duty_sum[7:0];
              end
              default: begin
                dig_nxt[0] = kdb_pkg::WORD_DOWN[0];
                dig_nxt[1] = kdb_pkg::WORD_DOWN[1];
                dig_nxt[2] = kdb_pkg::WORD_DOWN[2];
                duty_nxt   = (duty_r > duty_step_r) ? duty_r - duty_step_r : 8'd0;
              end
            endcase
          end
        end
      end
      kdb_pkg::OP_BYTE: begin
        word_nxt         = 1'b1;
        dig_nxt[0]       = seg_h | kdb_pkg::SEG_DOT;
        dig_nxt[1]       = seg_t | kdb_pkg::SEG_DOT;
        dig_nxt[2]       = seg_o | kdb_pkg::SEG_DOT;
        holdoff_left_nxt = holdoff_ticks_r;
        tone_period_nxt  = rx_tone_r;
        beep_left_nxt    = beep_ticks_r;
      end
      default: begin
        if (sample_take) begin
          word_nxt         = 1'b1;
          dig_nxt[0]       = seg_h;
          dig_nxt[1]       = seg_t;
          dig_nxt[2]       = seg_o | kdb_pkg::SEG_DOT;
          holdoff_left_nxt = sample_int_r;
        end
      end
    endcase
  end

  assign lit_idx = (lit_nxt == 2'd3) ? kdb_pkg::DIG_LOW : lit_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= 16'd500;
      holdoff_ticks_r  <= 16'd3000;
      sample_int_r     <= 16'd500;
      beep_ticks_r     <= 16'd100;
      key_tone_r       <= 8'd4;
      rx_tone_r        <= 8'd2;
      duty_step_r      <= 8'd10;
    end else if (cfg_we) begin
      case (kdb_pkg::cfg_idx_t'(cfg_index))
        kdb_pkg::CFG_DEBOUNCE:   debounce_ticks_r <= cfg_wdata;
        kdb_pkg::CFG_HOLDOFF:    holdoff_ticks_r  <= cfg_wdata;
        kdb_pkg::CFG_SAMPLE_INT: sample_int_r     <= cfg_wdata;
        kdb_pkg::CFG_BEEP:       beep_ticks_r     <= cfg_wdata;
        kdb_pkg::CFG_KEY_TONE:   key_tone_r       <= cfg_wdata[7:0];
        kdb_pkg::CFG_RX_TONE:    rx_tone_r        <= cfg_wdata[7:0];
        kdb_pkg::CFG_DUTY_STEP:  duty_step_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_left_r <= 16'd0;
      holdoff_left_r  <= 16'd0;
      beep_left_r     <= 16'd0;
      tone_count_r    <= 8'd0;
      tone_period_r   <= 8'd1;
      tone_level_r    <= 1'b0;
      column_r        <= 4'b0001;
      lit_r           <= kdb_pkg::DIG_LOW;
      dig_r[0]        <= 8'h00;
      dig_r[1]        <= 8'h00;
      dig_r[2]        <= 8'h00;
      word_r          <= 1'b0;
      duty_r          <= 8'd0;
    end else if (in_fire) begin
      debounce_left_r <= debounce_left_nxt;
      holdoff_left_r  <= holdoff_left_nxt;
      beep_left_r     <= beep_left_nxt;
      tone_count_r    <= tone_count_nxt;
      tone_period_r   <= tone_period_nxt;
      tone_level_r    <= tone_level_nxt;
      column_r        <= column_nxt;
      lit_r           <= lit_nxt;
      dig_r[0]        <= dig_nxt[0];
      dig_r[1]        <= dig_nxt[1];
      dig_r[2]        <= dig_nxt[2];
      word_r          <= word_nxt;
      duty_r          <= duty_nxt;
    end
  end

  // Output register: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_column_r <= column_nxt;
      out_digit_r  <= 3'b001 << lit_idx;
      out_seg_r    <= dig_nxt[lit_idx];
      out_buzz_r   <= tone_level_nxt;
      out_duty_r   <= duty_nxt;
      out_kv_r     <= key_take;
      out_kc_r     <= key_code_out;
      out_st_r     <= sample_take;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_drive  = out_column_r;
  assign out_digit_enable  = out_digit_r;
  assign out_segment_lines = out_seg_r;
  assign out_buzzer_level  = out_buzz_r;
  assign out_duty_value    = out_duty_r;
  assign out_key_valid     = out_kv_r;
  assign out_key_code      = out_kc_r;
  assign out_sample_taken  = out_st_r;

endmodule
`default_nettype wire
